// File: hw/rtl/wildcard_exclusion_filter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard exclusion filter
// Concurrent checks that are compiled away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_EXCLUSION_FILTER_CORE_ASSERT_SVH
`define WILDCARD_EXCLUSION_FILTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define WEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define WEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WEF_ASSERT(lbl, prop, msg)
`define WEF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/wef_pkg.sv
// ----------------------------------------------------------------------------
// wef_pkg
// Shared constants, types and match functions of the exclusion filter.
// ----------------------------------------------------------------------------
package wef_pkg;

  // Rule table geometry.
  localparam int MAX_RULES = 16;
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int RULE_W    = 46;

  // Wildcard values held in a rule field.
  localparam logic [2:0]  ANY_STAGE   = 3'h7;
  localparam logic [2:0]  ANY_TYPE    = 3'h7;
  localparam logic [7:0]  ANY_VARIANT = 8'hFF;
  localparam logic [15:0] ANY_INDEX   = 16'hFFFF;

  // Operation codes of an input word.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_DRAW_ENABLED = 1'b0;
  localparam logic REG_MIN_LOD      = 1'b1;

  typedef struct packed {
    logic [2:0]  stage;
    logic [2:0]  pass_type;
    logic [7:0]  variant;
    logic [15:0] pass_index;
    logic [15:0] sub_pass;
  } rule_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } wef_state_t;

  // A stored rule excludes the query when either index matches and the
  // remaining three fields all match.
  function automatic logic rule_match(rule_t r, rule_t q);
    logic idx_hit;
    idx_hit = (r.pass_index == ANY_INDEX) || (r.pass_index == q.pass_index) ||
              (r.sub_pass == ANY_INDEX) || (r.sub_pass == q.sub_pass);
    return idx_hit &&
           ((r.variant == ANY_VARIANT) || (r.variant == q.variant)) &&
           ((r.stage == ANY_STAGE) || (r.stage == q.stage)) &&
           ((r.pass_type == ANY_TYPE) || (r.pass_type == q.pass_type));
  endfunction

  // Exact equality of two rules, used to suppress duplicate adds.
  function automatic logic rule_equal(rule_t a, rule_t b);
    return a == b;
  endfunction

endpackage

// File: hw/rtl/wildcard_exclusion_filter_core.sv
// ----------------------------------------------------------------------------
// wildcard_exclusion_filter_core
// Stores exclusion rules with wildcard fields and answers drawability queries.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   ------------------------------------
//   config    psel/penable/pwrite       paddr, pwdata, prdata (pready = 1)
//   input     in_valid / in_ready       operation, stage, pass_type, variant,
//                                       pass_index, sub_pass, detail_level
//   output    out_valid / out_ready     drawable, rule_added, table_full
//
// While a word is scanned, the single read port of the rule RAM walks the
// stored rules one per cycle.
// One word is processed at a time; a finished result waits in the output
// register while the next word is accepted and scanned.
// A result that cannot leave the output register holds the scan in its final
// state. Synchronous reset empties the table at once (no clearing pass).
`include "wildcard_exclusion_filter_core_assert.svh"

module wildcard_exclusion_filter_core
  import wef_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [2:0]  stage,
  input  logic [2:0]  pass_type,
  input  logic [7:0]  variant,
  input  logic [15:0] pass_index,
  input  logic [15:0] sub_pass,
  input  logic [7:0]  detail_level,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        drawable,
  output logic        rule_added,
  output logic        table_full
);

  // Configuration registers.
  logic       draw_enabled;
  logic [7:0] min_lod;

  // Control state.
  wef_state_t       state, state_next;
  logic [CNT_W-1:0] rule_count, rule_count_next;
  logic [CNT_W-1:0] scan_idx, scan_idx_next;
  logic             rd_vld, rd_vld_next;
  logic             hit, hit_next;

  // Current word.
  rule_t cur_rule;
  logic  cur_op;
  logic  cur_ok;

  // RAM interface.
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [RULE_W-1:0] ram_rd_data;
  rule_t            rd_rule;

  // Result handling.
  logic in_fire;
  logic out_free;
  logic load_out;
  logic res_drawable;
  logic res_added;
  logic res_full;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration writes and reads; low address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_enabled <= 1'b1;
      min_lod      <= 8'hFF;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DRAW_ENABLED: draw_enabled <= pwdata[0];
        REG_MIN_LOD:      min_lod      <= pwdata[7:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DRAW_ENABLED: prdata = {31'd0, draw_enabled};
      REG_MIN_LOD:      prdata = {24'd0, min_lod};
      default:          prdata = '0;
    endcase
  end

  // Rule storage.
  wef_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES)
  ) u_rule_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (cur_rule),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_rule     = rule_t'(ram_rd_data);
  assign ram_rd_addr = scan_idx[IDX_W-1:0];
  assign ram_wr_addr = rule_count[IDX_W-1:0];

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Capture the incoming word; the query gate uses the settled config.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_op                <= operation;
      cur_rule.stage        <= stage;
      cur_rule.pass_type    <= pass_type;
      cur_rule.variant      <= variant;
      cur_rule.pass_index   <= pass_index;
      cur_rule.sub_pass     <= sub_pass;
      cur_ok                <= draw_enabled && (detail_level < min_lod);
    end
  end

  // Final result of the current word.
  always_comb begin
    res_drawable = 1'b0;
    res_added    = 1'b0;
    res_full     = 1'b0;
    if (cur_op == OP_QUERY) begin
      res_drawable = cur_ok && !hit;
    end else if (!hit) begin
      if (rule_count == CNT_W'(MAX_RULES)) begin
        res_full = 1'b1;
      end else begin
        res_added = 1'b1;
      end
    end
  end

  // Scan sequencer: one RAM read issued per cycle, compared in the cycle after.
  always_comb begin
    state_next      = state;
    scan_idx_next   = scan_idx;
    rd_vld_next     = 1'b0;
    hit_next        = hit;
    rule_count_next = rule_count;
    ram_rd_en       = 1'b0;
    ram_wr_en       = 1'b0;
    load_out        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          scan_idx_next = '0;
          hit_next      = 1'b0;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_rd_en = (scan_idx < rule_count);
        if (ram_rd_en) begin
          scan_idx_next = scan_idx + CNT_W'(1);
        end
        rd_vld_next = ram_rd_en;
        if (rd_vld) begin
          if (cur_op == OP_QUERY) begin
            hit_next = hit || rule_match(rd_rule, cur_rule);
          end else begin
            hit_next = hit || rule_equal(rd_rule, cur_rule);
          end
        end
        if (!ram_rd_en && !rd_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          ram_wr_en  = res_added;
          if (res_added) begin
            rule_count_next = rule_count + CNT_W'(1);
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rule_count <= '0;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
    end else begin
      state      <= state_next;
      rule_count <= rule_count_next;
      scan_idx   <= scan_idx_next;
      rd_vld     <= rd_vld_next;
      hit        <= hit_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drawable   <= res_drawable;
      rule_added <= res_added;
      table_full <= res_full;
    end
  end

  // Checks on the table bookkeeping and the scan.
  `WEF_ASSERT_ALWAYS(a_count_bound, rst || (rule_count <= CNT_W'(MAX_RULES)), "rule count over capacity")
  `WEF_ASSERT(a_read_in_range, ram_rd_en |-> (scan_idx < rule_count), "read past stored rules")
  `WEF_ASSERT(a_count_on_add, (rule_count != $past(rule_count)) |-> (out_valid && rule_added), "count moved without an added rule")
  `WEF_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "second word taken during a scan")

endmodule

// File: hw/rtl/wef_ram.sv
// ----------------------------------------------------------------------------
// wef_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for wildcard_exclusion_filter_core
// Drives add and query words with random idling on both channels. It predicts
// each result from its own copy of the rule table and the two registers, and
// compares every returned word with the oldest pending prediction.
// ----------------------------------------------------------------------------
module testbench;
  import wef_pkg::*;

  // Expected fields of one result word.
  typedef struct packed {
    logic drawable;
    logic rule_added;
    logic table_full;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [2:0]  stage;
  logic [2:0]  pass_type;
  logic [7:0]  variant;
  logic [15:0] pass_index;
  logic [15:0] sub_pass;
  logic [7:0]  detail_level;
  logic        out_valid;
  logic        out_ready;
  logic        drawable;
  logic        rule_added;
  logic        table_full;

  // Shadow copy of the filter state.
  rule_t       stored_rules [MAX_RULES];
  int unsigned stored_count;
  logic        cfg_draw_en;
  logic [7:0]  cfg_min_lod;

  verdict_t    pending_results [$];
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  logic        calm = 1'b0;

  wildcard_exclusion_filter_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .stage        (stage),
    .pass_type    (pass_type),
    .variant      (variant),
    .pass_index   (pass_index),
    .sub_pass     (sub_pass),
    .detail_level (detail_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drawable     (drawable),
    .rule_added   (rule_added),
    .table_full   (table_full)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic rule_t make_rule(input logic [2:0] s, input logic [2:0] t,
                                      input logic [7:0] v, input logic [15:0] idx,
                                      input logic [15:0] sp);
    rule_t r;
    r.stage      = s;
    r.pass_type  = t;
    r.variant    = v;
    r.pass_index = idx;
    r.sub_pass   = sp;
    return r;
  endfunction

  // Field values lean on the wildcard and a small pool so that rules and
  // queries collide often; the rest are fully random.
  function automatic logic [15:0] pick_value(input logic [15:0] ones);
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) begin
      return ones;
    end else if (sel <= 3) begin
      return 16'($urandom_range(0, 3));
    end
    return 16'($urandom) & ones;
  endfunction

  function automatic logic rule_is_stored(input rule_t r);
    for (int i = 0; i < stored_count; i++) begin
      if (stored_rules[i] == r) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the result of one accepted word and updates the shadow table.
  function automatic verdict_t filter_word(input logic op, input rule_t f,
                                           input logic [7:0] lod);
    verdict_t v;
    rule_t    s;
    logic     idx_hit;
    v = '0;
    if (op == OP_ADD) begin
      if (!rule_is_stored(f)) begin
        if (stored_count >= MAX_RULES) begin
          v.table_full = 1'b1;
        end else begin
          stored_rules[stored_count] = f;
          stored_count++;
          v.rule_added = 1'b1;
        end
      end
    end else begin
      v.drawable = cfg_draw_en && (lod < cfg_min_lod);
      for (int i = 0; i < stored_count; i++) begin
        s = stored_rules[i];
        // Either index alone is enough; the other three fields must all hit.
        idx_hit = (s.pass_index == ANY_INDEX) || (s.pass_index == f.pass_index) ||
                  (s.sub_pass == ANY_INDEX) || (s.sub_pass == f.sub_pass);
        if (idx_hit &&
            ((s.variant == ANY_VARIANT) || (s.variant == f.variant)) &&
            ((s.stage == ANY_STAGE) || (s.stage == f.stage)) &&
            ((s.pass_type == ANY_TYPE) || (s.pass_type == f.pass_type))) begin
          v.drawable = 1'b0;
        end
      end
    end
    return v;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Result checker: each returned word is matched with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("Unexpected result word: drawable=%0b added=%0b full=%0b",
                                drawable, rule_added, table_full));
      end else begin
        want = pending_results.pop_front();
        if (drawable !== want.drawable || rule_added !== want.rule_added ||
            table_full !== want.table_full) begin
          note_mismatch($sformatf(
            "Mismatch: expected drawable=%0b added=%0b full=%0b, got %0b %0b %0b",
            want.drawable, want.rule_added, want.table_full,
            drawable, rule_added, table_full));
        end
      end
    end
  end

  // Receiver side: random stall bursts, or always ready once calm is set.
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sends one word, with an occasional idle burst in front of it.
  task automatic send_word(input logic op, input rule_t f, input logic [7:0] lod);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    operation    <= op;
    stage        <= f.stage;
    pass_type    <= f.pass_type;
    variant      <= f.variant;
    pass_index   <= f.pass_index;
    sub_pass     <= f.sub_pass;
    detail_level <= lod;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(filter_word(op, f, lod));
  endtask

  // Reads a register back and compares it with the shadow value.
  task automatic read_back(input logic idx);
    logic [31:0] mask;
    logic [31:0] want;
    mask = (idx == REG_DRAW_ENABLED) ? 32'h1 : 32'hFF;
    want = (idx == REG_DRAW_ENABLED) ? {31'd0, cfg_draw_en} : {24'd0, cfg_min_lod};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== want) begin
      note_mismatch($sformatf("Register %0d read: expected %0h, got %0h",
                              idx, want, prdata & mask));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_DRAW_ENABLED) begin
      cfg_draw_en = value[0];
    end else begin
      cfg_min_lod = value[7:0];
    end
    read_back(idx);
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [7:0] lod_limit);
    wait_idle();
    write_reg(REG_DRAW_ENABLED, {31'd0, en});
    write_reg(REG_MIN_LOD, {24'd0, lod_limit});
  endtask

  // Reset values of both registers, and queries against the empty table.
  task automatic test_reset_defaults();
    read_back(REG_DRAW_ENABLED);
    read_back(REG_MIN_LOD);
    send_word(OP_QUERY, make_rule(0, 0, 0, 0, 0), 8'd0);
    send_word(OP_QUERY, make_rule(0, 0, 0, 0, 0), 8'd254);
    send_word(OP_QUERY, make_rule(0, 0, 0, 0, 0), 8'd255);
    send_word(OP_QUERY, make_rule(ANY_STAGE, ANY_TYPE, ANY_VARIANT, ANY_INDEX,
                                  ANY_INDEX), 8'd0);
  endtask

  // Global enable and the detail level threshold at their extremes.
  task automatic test_register_settings();
    set_config(1'b0, 8'd255);
    send_word(OP_QUERY, make_rule(1, 1, 1, 1, 1), 8'd0);
    set_config(1'b1, 8'd0);
    send_word(OP_QUERY, make_rule(1, 1, 1, 1, 1), 8'd0);
    set_config(1'b1, 8'd1);
    send_word(OP_QUERY, make_rule(1, 1, 1, 1, 1), 8'd0);
    send_word(OP_QUERY, make_rule(1, 1, 1, 1, 1), 8'd1);
    set_config(1'b1, 8'd255);
  endtask

  // Hand-made rules: duplicates, the index OR, and wildcards in each field.
  task automatic test_rule_matching();
    rule_t plain;
    plain = make_rule(2, 3, 5, 10, 20);
    send_word(OP_ADD, plain, 8'd0);
    send_word(OP_ADD, plain, 8'd77);
    send_word(OP_QUERY, plain, 8'd0);
    send_word(OP_QUERY, make_rule(2, 3, 5, 10, 99), 8'd0);
    send_word(OP_QUERY, make_rule(2, 3, 5, 99, 20), 8'd0);
    send_word(OP_QUERY, make_rule(2, 3, 5, 99, 99), 8'd0);
    send_word(OP_QUERY, make_rule(1, 3, 5, 10, 20), 8'd0);
    send_word(OP_QUERY, make_rule(2, 4, 5, 10, 20), 8'd0);
    send_word(OP_QUERY, make_rule(2, 3, 6, 10, 20), 8'd0);
    // Any stage, type and index: only the variant narrows this rule.
    send_word(OP_ADD, make_rule(ANY_STAGE, ANY_TYPE, 200, ANY_INDEX, 7), 8'd0);
    send_word(OP_QUERY, make_rule(0, 0, 200, 1, 1), 8'd0);
    // All-ones in a query is an ordinary value, not a wildcard.
    send_word(OP_QUERY, make_rule(ANY_STAGE, ANY_TYPE, ANY_VARIANT, ANY_INDEX,
                                  ANY_INDEX), 8'd0);
    // Any variant and any sub pass: stage and type decide.
    send_word(OP_ADD, make_rule(4, 1, ANY_VARIANT, 16'hFFFE, ANY_INDEX), 8'd0);
    send_word(OP_QUERY, make_rule(4, 1, 0, 0, 0), 8'd0);
    send_word(OP_QUERY, make_rule(4, 1, 0, 16'hFFFE, 0), 8'd0);
    send_word(OP_QUERY, make_rule(4, 2, 0, 0, 0), 8'd0);
  endtask

  // One phase of random traffic under a given register setting.
  task automatic run_random(input int unsigned count, input logic en,
                            input logic [7:0] lod_limit);
    logic  op;
    rule_t f;
    set_config(en, lod_limit);
    for (int unsigned n = 0; n < count; n++) begin
      op = ($urandom_range(0, 7) == 0) ? OP_ADD : OP_QUERY;
      if (op == OP_ADD && stored_count > 0 && $urandom_range(0, 2) == 0) begin
        f = stored_rules[$urandom_range(0, stored_count - 1)];
      end else begin
        f = make_rule(pick_value(16'h7), pick_value(16'h7), pick_value(16'hFF),
                      pick_value(16'hFFFF), pick_value(16'hFFFF));
        // Keep new rules from excluding nearly every query.
        if (op == OP_ADD && f.stage == ANY_STAGE && f.pass_type == ANY_TYPE) begin
          f.pass_type = 3'($urandom_range(0, 6));
        end
      end
      send_word(op, f, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    run_random(280, 1'b1, 8'd255);
    run_random(280, 1'b1, 8'($urandom_range(1, 254)));
    run_random(120, 1'b0, 8'($urandom_range(0, 255)));
    run_random(120, 1'b1, 8'd0);
    calm = 1'b1;
    run_random(280, 1'b1, 8'($urandom_range(128, 255)));
  endtask

  // Fills the table with specific rules, then adds a new and a stored rule and queries the stored one.
  task automatic test_full_table();
    rule_t f;
    do begin
      f = make_rule(3'($urandom_range(0, 6)), 3'($urandom_range(0, 6)),
                    8'($urandom_range(0, 254)), 16'($urandom_range(0, 65534)),
                    16'($urandom_range(0, 65534)));
      if (!rule_is_stored(f)) send_word(OP_ADD, f, 8'd0);
    end while (stored_count < MAX_RULES);
    do begin
      f = make_rule(3'($urandom_range(0, 6)), 3'($urandom_range(0, 6)),
                    8'($urandom_range(0, 254)), 16'($urandom_range(0, 65534)),
                    16'($urandom_range(0, 65534)));
    end while (rule_is_stored(f));
    send_word(OP_ADD, f, 8'd0);
    f = stored_rules[$urandom_range(0, MAX_RULES - 1)];
    send_word(OP_ADD, f, 8'd0);
    send_word(OP_QUERY, f, 8'd0);
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    operation    = OP_ADD;
    stage        = '0;
    pass_type    = '0;
    variant      = '0;
    pass_index   = '0;
    sub_pass     = '0;
    detail_level = '0;
    out_ready    = 1'b0;
    stored_count = 0;
    cfg_draw_en  = 1'b1;
    cfg_min_lod  = 8'd255;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_settings();
    test_rule_matching();
    test_random_traffic();
    test_full_table();

    wait_idle();
    repeat (30) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
